/* rtl/api_transmit_framer_with_status_macros.svh */
// Assertion macros for the API transmit framer with status readback.
// Included by the RTL file that checks its own logic (the framer); no other dependencies.
`ifndef API_TRANSMIT_FRAMER_WITH_STATUS_MACROS_SVH
`define API_TRANSMIT_FRAMER_WITH_STATUS_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising edge outside reset.
`define ATF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ATF_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ATF_ASSERT(label, clk, rst_n, prop, msg)
`define ATF_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* rtl/atf_pkg.sv */
// Shared types and constants of the API transmit framer with status readback.
// No dependencies; imported by every module of the block.
`default_nettype none

package atf_pkg;

    // Input item kinds (tuser of the slave side)
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_RX      = 2'd2;

    // Result kinds (tuser of the master side)
    localparam logic RES_TX_BYTE = 1'b0;
    localparam logic RES_STATUS  = 1'b1;

    // Frame bytes
    localparam logic [7:0] FRAME_DELIM    = 8'h7E;
    localparam logic [7:0] TYPE_TX_REQ    = 8'h10;
    localparam logic [7:0] TYPE_TX_STATUS = 8'h8B;
    localparam logic [7:0] TRL_ADDR_HI    = 8'hFF;
    localparam logic [7:0] TRL_ADDR_LO    = 8'hFE;
    localparam logic [7:0] TRL_ZERO       = 8'h00;
    localparam logic [7:0] CSUM_BASE      = 8'hFF;
    // Frame type plus the two fixed trailer address bytes, modulo 256
    localparam logic [7:0] SUM_SEED       = 8'h0D;
    localparam logic [15:0] HDR_LEN_ADD   = 16'd14;
    localparam logic [15:0] STATUS_LEN    = 16'd7;

    // Status body byte positions
    localparam logic [15:0] BODY_TYPE   = 16'd0;
    localparam logic [15:0] BODY_ID     = 16'd1;
    localparam logic [15:0] BODY_DELIV  = 16'd5;

    // Framer emission steps
    localparam logic [4:0] STEP_DELIM      = 5'd0;
    localparam logic [4:0] STEP_LEN_HI     = 5'd1;
    localparam logic [4:0] STEP_LEN_LO     = 5'd2;
    localparam logic [4:0] STEP_TYPE       = 5'd3;
    localparam logic [4:0] STEP_FRAME_ID   = 5'd4;
    localparam logic [4:0] STEP_ADDR_FIRST = 5'd5;
    localparam logic [4:0] STEP_ADDR_LAST  = 5'd12;
    localparam logic [4:0] STEP_TRL_FIRST  = 5'd13;
    localparam logic [4:0] STEP_TRL_FE     = 5'd14;
    localparam logic [4:0] STEP_TRL_Z0     = 5'd15;
    localparam logic [4:0] STEP_TRL_Z1     = 5'd16;
    localparam logic [4:0] STEP_CSUM       = 5'd17;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_len;
        logic [63:0] dest_address;
        logic [7:0]  data_byte;
    } t_item;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] tx_byte;
        logic       frame_end;
        logic       delivered;
        logic       last;
    } t_result;

    // Framer to receive parser
    typedef struct packed {
        logic en;       // parse this byte
        logic restart;  // frame sent, hunt for a delimiter
    } t_rx_ctl;

    // Receive parser to framer
    typedef struct packed {
        logic report;   // current byte closes a matching status frame
        logic ok;       // delivery status byte was zero
    } t_rx_stat;

endpackage

`default_nettype wire

/* rtl/api_transmit_framer_with_status.sv */
// Top level of the API transmit framer with status readback: input stage,
// framer, receive parser and result register. Depends on atf_pkg.
//
//  channel  | dir | tdata / tuser / tlast
//  s_axis   | in  | requests: start, payload byte or received link byte
//  m_axis   | out | results: transmit bytes and delivery status reports
//
// A payload or received byte gives at most one result; a start request gives the
// header (plus trailer and checksum with an empty payload), and the last payload
// byte also the trailer and checksum: the framer writes one result per cycle into
// the result register while it is free. Reset (i_rst_n low at a clock edge)
// clears all control state, sets the frame id to 1; no clearing pass. A stalled
// master side holds the result register and then back-pressures the slave side.
`default_nettype none

module api_transmit_framer_with_status import atf_pkg::*; #(
    parameter int unsigned MAX_PAYLOAD = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,   // payload_len[7:0], dest_address[71:8],
                                             // data_byte[79:72]
    input  wire logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // tx_byte[7:0], frame_end[8], delivered[9],
                                             // zero[15:10]
    output logic [0:0]       m_axis_tuser,   // result_kind[0]
    output logic             m_axis_tlast
);

    t_item    in_item;
    t_item    held_item;
    logic     held_vld;
    logic     consume;
    logic     out_free;
    logic     res_wr;
    t_result  res;
    t_rx_ctl  rx_ctl;
    t_rx_stat rx_stat;
    logic [7:0] frame_id;
    logic     r_out_vld;
    t_result  r_out;

    // Unpack the request
    assign in_item.kind         = s_axis_tuser;
    assign in_item.payload_len  = s_axis_tdata[7:0];
    assign in_item.dest_address = s_axis_tdata[71:8];
    assign in_item.data_byte    = s_axis_tdata[79:72];

    atf_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (s_axis_tvalid),
        .o_rdy     (s_axis_tready),
        .i_item    (in_item),
        .i_consume (consume),
        .o_vld     (held_vld),
        .o_item    (held_item)
    );

    atf_framer #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_framer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item_vld (held_vld),
        .i_item     (held_item),
        .i_out_free (out_free),
        .i_rx_stat  (rx_stat),
        .o_consume  (consume),
        .o_res_wr   (res_wr),
        .o_res      (res),
        .o_rx_ctl   (rx_ctl),
        .o_frame_id (frame_id)
    );

    atf_rx_parse u_rx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (rx_ctl),
        .i_byte     (held_item.data_byte),
        .i_frame_id (frame_id),
        .o_stat     (rx_stat)
    );

    // Result register: free when empty or being taken
    assign out_free = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_wr) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_wr) begin
            r_out <= res;
        end
    end

    // Pack the result
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'b000000, r_out.delivered, r_out.frame_end, r_out.tx_byte};
    assign m_axis_tuser  = r_out.result_kind;
    assign m_axis_tlast  = r_out.last;

endmodule

`default_nettype wire

/* rtl/atf_in_stage.sv */
// Input register stage of the API transmit framer: holds one request.
// Depends on atf_pkg for the item type.
`default_nettype none

module atf_in_stage import atf_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_vld,
    output logic       o_rdy,
    input  wire t_item i_item,
    input  wire logic  i_consume,
    output logic       o_vld,
    output t_item      o_item
);

    logic  r_vld;
    logic  n_vld;
    t_item r_item;
    logic  take;

    // Accept when empty or when the held request leaves this cycle
    assign o_rdy = !r_vld || i_consume;
    assign take  = i_vld && o_rdy;

    always_comb begin
        n_vld = r_vld;
        if (take) begin
            n_vld = 1'b1;
        end else if (i_consume) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Load payload on accept
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

`default_nettype wire

/* rtl/atf_rx_parse.sv */
// Receive parser: hunts for a delimiter and walks a link frame byte by byte.
// Depends on atf_pkg for the control and status structs and constants.
`default_nettype none

module atf_rx_parse import atf_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_rx_ctl  i_ctl,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_frame_id,
    output t_rx_stat      o_stat
);

    typedef enum logic [4:0] {
        RX_HUNT   = 5'b00001,
        RX_LEN_HI = 5'b00010,
        RX_LEN_LO = 5'b00100,
        RX_BODY   = 5'b01000,
        RX_CSUM   = 5'b10000
    } t_rx_phase;

    t_rx_phase   r_phase, n_phase;
    logic [15:0] r_len, n_len;
    logic [15:0] r_idx, n_idx;
    logic        r_match, n_match;
    logic        r_ok, n_ok;
    logic [15:0] len_full;
    logic [15:0] idx_inc;

    assign len_full = {r_len[15:8], i_byte};
    assign idx_inc  = r_idx + 16'd1;

    // Advance the parser on each byte handed over
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_idx   = r_idx;
        n_match = r_match;
        n_ok    = r_ok;
        if (i_ctl.restart) begin
            n_phase = RX_HUNT;
        end else if (i_ctl.en) begin
            unique case (r_phase)
                RX_HUNT: begin
                    if (i_byte == FRAME_DELIM) begin
                        n_phase = RX_LEN_HI;
                    end
                end
                RX_LEN_HI: begin
                    n_len   = {i_byte, 8'h00};
                    n_phase = RX_LEN_LO;
                end
                RX_LEN_LO: begin
                    n_len   = len_full;
                    n_idx   = 16'd0;
                    n_match = (len_full == STATUS_LEN);
                    n_ok    = 1'b1;
                    n_phase = (len_full == 16'd0) ? RX_CSUM : RX_BODY;
                end
                RX_BODY: begin
                    if (r_idx == BODY_TYPE && i_byte != TYPE_TX_STATUS) begin
                        n_match = 1'b0;
                    end
                    if (r_idx == BODY_ID && i_byte != i_frame_id) begin
                        n_match = 1'b0;
                    end
                    if (r_idx == BODY_DELIV) begin
                        n_ok = (i_byte == 8'h00);
                    end
                    n_idx = idx_inc;
                    if (idx_inc >= r_len) begin
                        n_phase = RX_CSUM;
                    end
                end
                default: begin
                    // checksum byte is skipped unverified
                    n_phase = RX_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= RX_HUNT;
            r_len   <= 16'd0;
            r_idx   <= 16'd0;
            r_match <= 1'b0;
            r_ok    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_match <= n_match;
            r_ok    <= n_ok;
        end
    end

    assign o_stat.report = (r_phase == RX_CSUM) && r_match;
    assign o_stat.ok     = r_ok;

endmodule

`default_nettype wire

/* rtl/atf_framer.sv */
// Framer: sequences header, payload, trailer and status results, one per cycle
// with a free output; keeps frame state; depends on atf_pkg, assertion macros.
`default_nettype none
`include "api_transmit_framer_with_status_macros.svh"

module atf_framer import atf_pkg::*; #(
    parameter int unsigned MAX_PAYLOAD = 255
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_item_vld,
    input  wire t_item    i_item,
    input  wire logic     i_out_free,
    input  wire t_rx_stat i_rx_stat,
    output logic          o_consume,
    output logic          o_res_wr,
    output t_result       o_res,
    output t_rx_ctl       o_rx_ctl,
    output logic [7:0]    o_frame_id
);

    localparam logic [7:0] MaxLen = (MAX_PAYLOAD > 255) ? 8'hFF : 8'(MAX_PAYLOAD);

    logic [4:0]  r_step, n_step;
    logic [7:0]  r_frame_id, n_frame_id;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_left, n_left;
    logic        r_sending, n_sending;
    logic        r_awaiting, n_awaiting;
    logic [7:0]  plen_sat;
    logic [15:0] total;
    logic [4:0]  addr_sel;
    logic [7:0]  addr_byte;
    logic [7:0]  step_byte;
    logic        emit;
    logic        done;
    t_result     res;
    t_rx_ctl     rx_ctl;

    // Saturate the payload count and form the length field
    assign plen_sat  = (i_item.payload_len > MaxLen) ? MaxLen : i_item.payload_len;
    assign total     = {8'h00, plen_sat} + HDR_LEN_ADD;
    assign addr_sel  = STEP_ADDR_LAST - r_step;
    assign addr_byte = i_item.dest_address[{addr_sel[2:0], 3'b000} +: 8];

    // Select the header or trailer byte for the current step
    always_comb begin
        case (r_step) inside
            STEP_DELIM:                       step_byte = FRAME_DELIM;
            STEP_LEN_HI:                      step_byte = total[15:8];
            STEP_LEN_LO:                      step_byte = total[7:0];
            STEP_TYPE:                        step_byte = TYPE_TX_REQ;
            STEP_FRAME_ID:                    step_byte = r_frame_id;
            [STEP_ADDR_FIRST:STEP_ADDR_LAST]: step_byte = addr_byte;
            STEP_TRL_FIRST:                   step_byte = TRL_ADDR_HI;
            STEP_TRL_FE:                      step_byte = TRL_ADDR_LO;
            STEP_TRL_Z0, STEP_TRL_Z1:         step_byte = TRL_ZERO;
            default:                          step_byte = CSUM_BASE - r_sum;
        endcase
    end

    // One result per cycle while the output is free; advance the frame state
    always_comb begin
        n_step     = r_step;
        n_frame_id = r_frame_id;
        n_sum      = r_sum;
        n_left     = r_left;
        n_sending  = r_sending;
        n_awaiting = r_awaiting;
        emit       = 1'b0;
        done       = 1'b0;
        res        = '0;
        rx_ctl     = '0;
        if (i_item_vld) begin
            if (r_step >= STEP_TRL_FIRST) begin
                // trailer and checksum
                emit        = 1'b1;
                res.tx_byte = step_byte;
                if (r_step == STEP_CSUM) begin
                    res.frame_end = 1'b1;
                    res.last      = 1'b1;
                end
                if (i_out_free) begin
                    if (r_step == STEP_CSUM) begin
                        done           = 1'b1;
                        n_step         = STEP_DELIM;
                        n_sending      = 1'b0;
                        n_awaiting     = 1'b1;
                        rx_ctl.restart = 1'b1;
                    end else begin
                        n_step = r_step + 5'd1;
                    end
                end
            end else begin
                unique case (i_item.kind)
                    KIND_START: begin
                        if (r_step == STEP_DELIM && (r_sending || r_awaiting)) begin
                            // drop: a frame is in flight
                            done = 1'b1;
                        end else begin
                            emit        = 1'b1;
                            res.tx_byte = step_byte;
                            res.last    = (r_step == STEP_ADDR_LAST) && (r_left != 8'd0);
                            if (i_out_free) begin
                                if (r_step == STEP_DELIM) begin
                                    n_sum     = SUM_SEED;
                                    n_left    = plen_sat;
                                    n_sending = 1'b1;
                                end else if (r_step == STEP_FRAME_ID) begin
                                    n_sum = r_sum + r_frame_id;
                                end else if (r_step >= STEP_ADDR_FIRST) begin
                                    n_sum = r_sum + addr_byte;
                                end
                                if (r_step == STEP_ADDR_LAST) begin
                                    if (r_left == 8'd0) begin
                                        n_step = STEP_TRL_FIRST;
                                    end else begin
                                        done   = 1'b1;
                                        n_step = STEP_DELIM;
                                    end
                                end else begin
                                    n_step = r_step + 5'd1;
                                end
                            end
                        end
                    end
                    KIND_PAYLOAD: begin
                        if (!r_sending) begin
                            done = 1'b1;
                        end else begin
                            emit        = 1'b1;
                            res.tx_byte = i_item.data_byte;
                            res.last    = (r_left != 8'd1);
                            if (i_out_free) begin
                                n_sum  = r_sum + i_item.data_byte;
                                n_left = r_left - 8'd1;
                                if (r_left == 8'd1) begin
                                    n_step = STEP_TRL_FIRST;
                                end else begin
                                    done = 1'b1;
                                end
                            end
                        end
                    end
                    KIND_RX: begin
                        if (!r_awaiting) begin
                            done = 1'b1;
                        end else if (i_rx_stat.report) begin
                            emit            = 1'b1;
                            res.result_kind = RES_STATUS;
                            res.delivered   = i_rx_stat.ok;
                            res.last        = 1'b1;
                            if (i_out_free) begin
                                done       = 1'b1;
                                rx_ctl.en  = 1'b1;
                                n_awaiting = 1'b0;
                                n_frame_id = (r_frame_id == 8'hFF) ? 8'd1
                                                                   : r_frame_id + 8'd1;
                            end
                        end else begin
                            done      = 1'b1;
                            rx_ctl.en = 1'b1;
                        end
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= STEP_DELIM;
            r_frame_id <= 8'd1;
            r_sum      <= 8'd0;
            r_left     <= 8'd0;
            r_sending  <= 1'b0;
            r_awaiting <= 1'b0;
        end else begin
            r_step     <= n_step;
            r_frame_id <= n_frame_id;
            r_sum      <= n_sum;
            r_left     <= n_left;
            r_sending  <= n_sending;
            r_awaiting <= n_awaiting;
        end
    end

    assign o_consume  = done;
    assign o_res_wr   = emit && i_out_free;
    assign o_res      = res;
    assign o_rx_ctl   = rx_ctl;
    assign o_frame_id = r_frame_id;

    `ATF_NEVER(a_id_nonzero, i_clk, i_rst_n, r_frame_id == 8'd0, "frame id reached zero")
    `ATF_ASSERT(a_step_in_frame, i_clk, i_rst_n, (r_step != STEP_DELIM) |-> r_sending, "step advanced outside a frame")
    `ATF_ASSERT(a_csum_arms, i_clk, i_rst_n, (o_res_wr && o_res.frame_end) |=> (r_awaiting && !r_sending), "checksum did not arm status wait")
    `ATF_ASSERT(a_id_advance, i_clk, i_rst_n, (o_res_wr && o_res.result_kind == RES_STATUS) |=> (r_frame_id != $past(r_frame_id) && !r_awaiting), "status did not advance frame id")

endmodule

`default_nettype wire

/* test/api_transmit_framer_with_status_tb.sv */
// Testbench of the API transmit framer with status readback: a directed table and
// random framed link traffic, checked against a cycle-free predictor or, for typed rows, the row itself.
// Depends on atf_pkg and the api_transmit_framer_with_status RTL.
module api_transmit_framer_with_status_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import atf_pkg::*;

    // Request kind that the framer does not decode
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int MAX_PAYLOAD = 255;
    // Random requests after the directed table, the last of them without idling
    localparam int N_RANDOM = 285;
    localparam int N_QUIET  = 40;
    localparam logic [63:0] ADDR_ONES = '1;

    localparam t_result NO_RES        = '0;
    localparam t_result DELIVERED_RES = '{RES_STATUS, 8'h00, 1'b0, 1'b1, 1'b1};

    typedef enum logic [2:0] {
        LK_HUNT,
        LK_LEN_HI,
        LK_LEN_LO,
        LK_BODY,
        LK_CSUM
    } t_link_phase;

    typedef enum int {
        FR_GOOD,
        FR_BAD_LEN,
        FR_BAD_TYPE,
        FR_BAD_ID
    } t_frame_variant;

    // One directed request; typed rows carry their own expectation (none or one result)
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  plen;
        logic [63:0] addr;
        logic [7:0]  data;
        logic        typed;
        logic        one;
        t_result     res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;     // payload_len[7:0], dest_address[71:8], data_byte[79:72]
    logic [1:0]  s_axis_tuser = '0;     // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // tx_byte[7:0], frame_end[8], delivered[9], zero[15:10]
    logic [0:0]  m_axis_tuser;          // result_kind[0]
    logic        m_axis_tlast;

    // Predictor state
    logic [7:0]  fr_id = 8'd1;
    logic [7:0]  fr_sum = '0;
    logic [7:0]  fr_left = '0;
    logic        fr_sending = 1'b0;
    logic        fr_awaiting = 1'b0;
    t_link_phase lk_phase = LK_HUNT;
    logic [15:0] lk_len = '0;
    logic [15:0] lk_idx = '0;
    logic        lk_match = 1'b0;
    logic        lk_ok = 1'b0;

    t_result     step_out[$];
    t_result     want_out_q[$];
    logic [7:0]  rx_plan[$];
    int          mismatches = 0;
    int          random_items = 0;
    int          stall_left = 0;
    bit          quiet = 1'b0;
    bit          long_sent = 1'b0;

    t_dir_row dir_rows [0:24] = '{
        // requests the idle framer drops
        '{KIND_RX,      8'h00, 64'h0,     FRAME_DELIM, 1'b1, 1'b0, NO_RES},
        '{KIND_PAYLOAD, 8'h00, 64'h0,     8'hAA,       1'b1, 1'b0, NO_RES},
        '{KIND_UNUSED,  8'hFF, ADDR_ONES, 8'hFF,       1'b1, 1'b0, NO_RES},
        // empty payload: header, trailer and checksum at once
        '{KIND_START,   8'h00, ADDR_ONES, 8'h00,       1'b0, 1'b0, NO_RES},
        // start and payload while a status is awaited
        '{KIND_START,   8'h05, 64'h1,     8'h00,       1'b1, 1'b0, NO_RES},
        '{KIND_PAYLOAD, 8'h00, 64'h0,     8'h55,       1'b1, 1'b0, NO_RES},
        // matching status frame for id 1, delivered
        '{KIND_RX,      8'h00, 64'h0,     8'h00,       1'b1, 1'b0, NO_RES},
        '{KIND_RX,      8'h00, 64'h0,     FRAME_DELIM, 1'b1, 1'b0, NO_RES},
        '{KIND_RX,      8'h00, 64'h0,     8'h00,       1'b1, 1'b0, NO_RES},
        '{KIND_RX,      8'h00, 64'h0,     8'h07,       1'b1, 1'b0, NO_RES},
        '{KIND_RX,      8'h00, 64'h0,     TYPE_TX_STATUS, 1'b1, 1'b0, NO_RES},
        '{KIND_RX,      8'h00, 64'h0,     8'h01,       1'b1, 1'b0, NO_RES},
        '{KIND_RX,      8'h00, 64'h0,     8'h00,       1'b1, 1'b0, NO_RES},
        '{KIND_RX,      8'h00, 64'h0,     8'h00,       1'b1, 1'b0, NO_RES},
        '{KIND_RX,      8'h00, 64'h0,     8'h00,       1'b1, 1'b0, NO_RES},
        '{KIND_RX,      8'h00, 64'h0,     8'h00,       1'b1, 1'b0, NO_RES},
        '{KIND_RX,      8'h00, 64'h0,     8'h00,       1'b1, 1'b0, NO_RES},
        '{KIND_RX,      8'h00, 64'h0,     8'h5A,       1'b1, 1'b1, DELIVERED_RES},
        // one-byte frame with a start and an unknown kind while sending
        '{KIND_START,   8'h01, 64'h0,     8'h00,       1'b0, 1'b0, NO_RES},
        '{KIND_START,   8'h03, ADDR_ONES, 8'h00,       1'b1, 1'b0, NO_RES},
        '{KIND_UNUSED,  8'h00, 64'h0,     8'h00,       1'b1, 1'b0, NO_RES},
        '{KIND_PAYLOAD, 8'h00, 64'h0,     8'hFF,       1'b0, 1'b0, NO_RES},
        // zero-length link frame: skipped up to its checksum
        '{KIND_RX,      8'h00, 64'h0,     FRAME_DELIM, 1'b1, 1'b0, NO_RES},
        '{KIND_RX,      8'h00, 64'h0,     8'h00,       1'b1, 1'b0, NO_RES},
        '{KIND_RX,      8'h00, 64'h0,     8'h00,       1'b1, 1'b0, NO_RES}
    };

    always #5 i_clk = ~i_clk;

    api_transmit_framer_with_status #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
        mismatches++;
        $display("mismatch in %s at %0t: got %0h, want %0h", field, $realtime, got, want);
    endtask

    function automatic void emit(logic kind_r, logic [7:0] b, logic fe, logic dl);
        t_result r;
        r.result_kind = kind_r;
        r.tx_byte     = b;
        r.frame_end   = fe;
        r.delivered   = dl;
        r.last        = 1'b0;
        step_out.push_back(r);
    endfunction

    // Close the frame: fixed trailer, checksum, then wait for the status frame
    function automatic void emit_trailer();
        emit(RES_TX_BYTE, TRL_ADDR_HI, 1'b0, 1'b0);
        emit(RES_TX_BYTE, TRL_ADDR_LO, 1'b0, 1'b0);
        emit(RES_TX_BYTE, TRL_ZERO, 1'b0, 1'b0);
        emit(RES_TX_BYTE, TRL_ZERO, 1'b0, 1'b0);
        emit(RES_TX_BYTE, CSUM_BASE - fr_sum, 1'b1, 1'b0);
        fr_sending  = 1'b0;
        fr_awaiting = 1'b1;
        lk_phase    = LK_HUNT;
    endfunction

    // Work out the results of one accepted request into step_out
    function automatic void framer_predict(t_item it);
        int unsigned plen;
        logic [15:0] total;
        logic [7:0]  b;
        t_result     r;
        step_out.delete();
        case (it.kind)
            KIND_START: begin
                if (!fr_sending && !fr_awaiting) begin
                    plen = 32'(it.payload_len);
                    if (plen > MAX_PAYLOAD)
                        plen = MAX_PAYLOAD;
                    total = 16'(plen) + HDR_LEN_ADD;
                    emit(RES_TX_BYTE, FRAME_DELIM, 1'b0, 1'b0);
                    emit(RES_TX_BYTE, total[15:8], 1'b0, 1'b0);
                    emit(RES_TX_BYTE, total[7:0], 1'b0, 1'b0);
                    emit(RES_TX_BYTE, TYPE_TX_REQ, 1'b0, 1'b0);
                    emit(RES_TX_BYTE, fr_id, 1'b0, 1'b0);
                    fr_sum = SUM_SEED + fr_id;
                    for (int i = 7; i >= 0; i--) begin
                        b = it.dest_address[8*i +: 8];
                        emit(RES_TX_BYTE, b, 1'b0, 1'b0);
                        fr_sum = fr_sum + b;
                    end
                    fr_left    = plen[7:0];
                    fr_sending = 1'b1;
                    if (plen == 0)
                        emit_trailer();
                end
            end
            KIND_PAYLOAD: begin
                if (fr_sending) begin
                    emit(RES_TX_BYTE, it.data_byte, 1'b0, 1'b0);
                    fr_sum  = fr_sum + it.data_byte;
                    fr_left = fr_left - 8'd1;
                    if (fr_left == 0)
                        emit_trailer();
                end
            end
            KIND_RX: begin
                if (fr_awaiting) begin
                    case (lk_phase)
                        LK_HUNT: begin
                            if (it.data_byte == FRAME_DELIM)
                                lk_phase = LK_LEN_HI;
                        end
                        LK_LEN_HI: begin
                            lk_len   = {it.data_byte, 8'h00};
                            lk_phase = LK_LEN_LO;
                        end
                        LK_LEN_LO: begin
                            lk_len   = {lk_len[15:8], it.data_byte};
                            lk_idx   = '0;
                            lk_match = (lk_len == STATUS_LEN);
                            lk_ok    = 1'b1;
                            lk_phase = (lk_len == 0) ? LK_CSUM : LK_BODY;
                        end
                        LK_BODY: begin
                            if (lk_idx == BODY_TYPE && it.data_byte != TYPE_TX_STATUS)
                                lk_match = 1'b0;
                            if (lk_idx == BODY_ID && it.data_byte != fr_id)
                                lk_match = 1'b0;
                            if (lk_idx == BODY_DELIV)
                                lk_ok = (it.data_byte == 8'h00);
                            lk_idx = lk_idx + 16'd1;
                            if (lk_idx >= lk_len)
                                lk_phase = LK_CSUM;
                        end
                        default: begin
                            // checksum byte: report on a match, never verify it
                            lk_phase = LK_HUNT;
                            if (lk_match) begin
                                emit(RES_STATUS, 8'h00, 1'b0, lk_ok);
                                fr_awaiting = 1'b0;
                                if (fr_id == 8'hFF)
                                    fr_id = 8'd1;
                                else
                                    fr_id = fr_id + 8'd1;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
        if (step_out.size() != 0) begin
            r = step_out.pop_back();
            r.last = 1'b1;
            step_out.push_back(r);
        end
    endfunction

    // Drive one request, hold it until accepted, then queue what it should cause
    task automatic issue(t_item it, bit typed, bit typed_one, t_result typed_res);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.data_byte, it.dest_address, it.payload_len};
        s_axis_tuser  <= it.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        framer_predict(it);
        if (!typed) begin
            foreach (step_out[i])
                want_out_q.push_back(step_out[i]);
        end else if (typed_one) begin
            want_out_q.push_back(typed_res);
        end
    endtask

    // Append one link frame to the receive plan
    function automatic void push_link_frame(t_frame_variant v);
        logic [7:0] len_lo;
        logic [7:0] b;
        len_lo = STATUS_LEN[7:0];
        if (v == FR_BAD_LEN) begin
            len_lo = 8'($urandom_range(0, 11));
            if (len_lo >= STATUS_LEN[7:0])
                len_lo = len_lo + 8'd1;
        end
        rx_plan.push_back(FRAME_DELIM);
        rx_plan.push_back(8'h00);
        rx_plan.push_back(len_lo);
        for (int i = 0; i < len_lo; i++) begin
            b = 8'($urandom);
            if (i == BODY_TYPE) begin
                b = TYPE_TX_STATUS;
                if (v == FR_BAD_TYPE) begin
                    b = 8'($urandom);
                    if (b == TYPE_TX_STATUS)
                        b = ~b;
                end
            end
            if (i == BODY_ID)
                b = (v == FR_BAD_ID) ? fr_id ^ 8'($urandom_range(1, 255)) : fr_id;
            if (i == BODY_DELIV && $urandom_range(0, 1) == 1)
                b = 8'h00;
            rx_plan.push_back(b);
        end
        rx_plan.push_back(8'($urandom));
    endfunction

    // Plan link bytes up to a matching status frame; clean plans skip noise and bad frames
    function automatic void plan_link_bytes(bit clean);
        if (!clean) begin
            repeat ($urandom_range(0, 2))
                rx_plan.push_back(8'($urandom));
            repeat ($urandom_range(0, 2))
                push_link_frame(t_frame_variant'($urandom_range(1, 3)));
        end
        push_link_frame(FR_GOOD);
    endfunction

    // Pick and issue the next request from the predicted framer state
    task automatic random_step(bit sweep);
        t_item it;
        bit    noise;
        int    r;
        it.kind         = KIND_START;
        it.payload_len  = 8'($urandom);
        it.dest_address = {$urandom, $urandom};
        it.data_byte    = 8'($urandom);
        noise = !sweep && $urandom_range(0, 19) == 0;
        if (!fr_awaiting)
            rx_plan.delete();
        if (noise) begin
            // unknown kind, or a request the current state drops
            if ($urandom_range(0, 1) == 0)
                it.kind = KIND_UNUSED;
            else if (fr_sending)
                it.kind = KIND_START;
            else if (fr_awaiting)
                it.kind = $urandom_range(0, 1) ? KIND_START : KIND_PAYLOAD;
            else
                it.kind = $urandom_range(0, 1) ? KIND_PAYLOAD : KIND_RX;
        end else if (fr_sending) begin
            it.kind = KIND_PAYLOAD;
        end else if (fr_awaiting) begin
            if (rx_plan.size() == 0)
                plan_link_bytes(sweep);
            it.kind      = KIND_RX;
            it.data_byte = rx_plan.pop_front();
        end else begin
            r = $urandom_range(0, 9);
            if (sweep) begin
                it.payload_len = 8'd0;
            end else if (!long_sent) begin
                it.payload_len = 8'd255;
                long_sent      = 1'b1;
            end else if (r < 3) begin
                it.payload_len = 8'd0;
            end else if (r == 9) begin
                it.payload_len = 8'($urandom_range(13, 30));
            end else begin
                it.payload_len = 8'($urandom_range(1, 12));
            end
        end
        issue(it, 1'b0, 1'b0, NO_RES);
        random_items++;
    endtask

    // Check results and stall the result side in bursts
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[9],
                       m_axis_tlast};
                if (m_axis_tdata[15:10] !== '0)
                    report_mismatch("padding", m_axis_tdata, '0);
                if (want_out_q.size() == 0) begin
                    report_mismatch("unexpected result", 16'(got), '0);
                end else begin
                    want = want_out_q.pop_front();
                    if (got.result_kind !== want.result_kind)
                        report_mismatch("result_kind", 16'(got.result_kind),
                                        16'(want.result_kind));
                    if (got.tx_byte !== want.tx_byte)
                        report_mismatch("tx_byte", 16'(got.tx_byte), 16'(want.tx_byte));
                    if (got.frame_end !== want.frame_end)
                        report_mismatch("frame_end", 16'(got.frame_end), 16'(want.frame_end));
                    if (got.delivered !== want.delivered)
                        report_mismatch("delivered", 16'(got.delivered), 16'(want.delivered));
                    if (got.last !== want.last)
                        report_mismatch("last", 16'(got.last), 16'(want.last));
                end
            end
            if (stall_left == 0 && !quiet && $urandom_range(0, 11) == 0)
                stall_left = $urandom_range(1, 10);
            m_axis_tready <= (stall_left == 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    // Main sequence: reset, directed table, random traffic, drain
    initial begin
        t_item it;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[i]) begin
            it.kind         = dir_rows[i].kind;
            it.payload_len  = dir_rows[i].plen;
            it.dest_address = dir_rows[i].addr;
            it.data_byte    = dir_rows[i].data;
            issue(it, dir_rows[i].typed, dir_rows[i].one, dir_rows[i].res);
        end
        while (random_items < N_RANDOM) begin
            quiet = (random_items >= N_RANDOM - N_QUIET);
            random_step(1'b0);
        end
        s_axis_tvalid <= 1'b0;
        while (want_out_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("** api_transmit_framer_with_status: PASSED **");
        else
            $display("** api_transmit_framer_with_status: FAILED **");
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #10_000_000;
        $display("** api_transmit_framer_with_status: FAILED **");
        $finish;
    end

endmodule
